>>> sv/uule_pkg.sv
// Shared constants, types and the six-bit character map of the line encoder.
// Depends on nothing; every other file of the block but uule_ram imports it.
`default_nettype none

package uule_pkg;

  // Bytes gathered into one text line.
  localparam int LINE_BYTES = 45;
  // Byte count width: holds LINE_BYTES itself.
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);
  // Line store address width.
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  // Width of a count with headroom for a group step.
  localparam int SUM_W      = CNT_W + 1;
  localparam int CHAR_W     = 7;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 3 * BYTE_W;

  localparam logic [CHAR_W-1:0] NEWLINE     = 7'd10;
  localparam logic [CHAR_W-1:0] BACKQUOTE   = 7'd96;
  localparam logic [CHAR_W-1:0] CHAR_OFFSET = 7'd32;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_READ,
    ST_LOAD,
    ST_CHAR,
    ST_NL
  } state_t;

  // Kind of character being sent.
  typedef enum logic [1:0] {
    KIND_LEN,
    KIND_DATA,
    KIND_NL
  } kind_t;

  // Controls from the sequencer to the group datapath.
  typedef struct packed {
    logic       load;
    logic [1:0] lane;
    logic       byte_ok;
    logic       shift;
    kind_t      kind;
    logic       last;
  } grp_ctrl_t;

  // One result item.
  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              line_done;
    logic              stream_done;
  } out_item_t;

  // Zero is sent as backquote, any other value v as v + 32.
  function automatic logic [CHAR_W-1:0] sixbit_char(input logic [5:0] v);
    logic [CHAR_W-1:0] ch;
    if (v == 6'd0) begin
      ch = BACKQUOTE;
    end else begin
      ch = {1'b0, v} + CHAR_OFFSET;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/uule_byte_if.sv
// Input channel of the line encoder: one raw byte and its end flag per item.
// Depends on uule_pkg for the field widths.
`default_nettype none

interface uule_byte_if
  import uule_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_data;

  modport source (output valid, data_byte, end_of_data, input ready);
  modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

`default_nettype wire

>>> sv/uule_char_if.sv
// Output channel of the line encoder: one text character per item.
// Depends on uule_pkg for the field widths.
`default_nettype none

interface uule_char_if
  import uule_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              line_done;
  logic              stream_done;

  modport source (output valid, text_char, line_done, stream_done, input ready);
  modport sink   (input valid, text_char, line_done, stream_done, output ready);
endinterface

`default_nettype wire

>>> sv/uule_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; used for the line store.
`default_nettype none

module uule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sv/uule_group.sv
// Group datapath: the shared 24-bit word that is loaded byte by byte and
// shifted out six bits at a time, with the character map. Depends on uule_pkg.
`default_nettype none

module uule_group
  import uule_pkg::*;
(
  input  wire logic              clk,
  input  wire grp_ctrl_t         ctrl,
  input  wire logic [BYTE_W-1:0] rd_data,
  input  wire logic [CNT_W-1:0]  line_cnt,
  output out_item_t              item
);

  logic [WORD_W-1:0] word;

  // Bytes beyond the end of the line load as zero; a char step shifts six bits.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word[5'({ctrl.lane, 3'b000}) +: BYTE_W] <= ctrl.byte_ok ? rd_data : '0;
    end else if (ctrl.shift) begin
      word <= word >> 6;
    end
  end

  // Character selection for the item about to be sent.
  always_comb begin
    item = '{text_char: '0, line_done: 1'b0, stream_done: 1'b0};
    case (ctrl.kind)
      KIND_LEN:  item.text_char = sixbit_char(6'(line_cnt));
      KIND_DATA: item.text_char = sixbit_char(word[5:0]);
      KIND_NL: begin
        item.text_char   = NEWLINE;
        item.line_done   = 1'b1;
        item.stream_done = ctrl.last;
      end
      default:   item.text_char = NEWLINE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/uule_seq.sv
// Sequencer: gathers bytes into the line store and, when a line closes, steps
// through its groups and characters. Depends on uule_pkg.
`default_nettype none

module uule_seq
  import uule_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_end,
  output logic                   in_ready,
  input  wire logic              slot_free,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  output logic                   emit,
  output grp_ctrl_t              ctrl,
  output logic [CNT_W-1:0]       line_cnt
);

  state_t           state, state_next;
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] base;
  logic [1:0]       lane;
  logic [1:0]       chr;
  logic             last_flag;
  logic             rd_valid;
  logic             accept;
  logic             close;
  logic             in_range;
  logic             group_end;
  logic [SUM_W-1:0] lane_addr;

  // Item acceptance and line closing.
  assign accept    = in_valid && in_ready;
  assign count_inc = held_count + CNT_W'(1);
  assign close     = accept && ((count_inc == CNT_W'(LINE_BYTES)) || in_end);

  // Address of the byte being fetched and end-of-line tests.
  assign lane_addr = {1'b0, base} + SUM_W'(lane);
  assign in_range  = lane_addr < {1'b0, line_cnt};
  assign group_end = ({1'b0, base} + SUM_W'(3)) >= {1'b0, line_cnt};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (close) state_next = ST_LEN;
      ST_LEN:  if (slot_free) state_next = ST_READ;
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = (lane == 2'd2) ? ST_CHAR : ST_READ;
      ST_CHAR: begin
        if (slot_free && (chr == 2'd3)) begin
          state_next = group_end ? ST_NL : ST_READ;
        end
      end
      ST_NL:   if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready     = 1'b0;
    rd_en        = 1'b0;
    emit         = 1'b0;
    ctrl.load    = 1'b0;
    ctrl.lane    = lane;
    ctrl.byte_ok = rd_valid;
    ctrl.shift   = 1'b0;
    ctrl.kind    = KIND_DATA;
    ctrl.last    = last_flag;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_LEN: begin
        ctrl.kind = KIND_LEN;
        emit      = slot_free;
      end
      ST_READ: rd_en = in_range;
      ST_LOAD: ctrl.load = 1'b1;
      ST_CHAR: begin
        emit       = slot_free;
        ctrl.shift = slot_free;
      end
      ST_NL: begin
        ctrl.kind = KIND_NL;
        emit      = slot_free;
      end
      default: in_ready = 1'b0;
    endcase
  end

  assign wr_en   = accept;
  assign wr_addr = held_count[ADDR_W-1:0];
  assign rd_addr = lane_addr[ADDR_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        held_count <= close ? '0 : count_inc;
      end
    end
  end

  // Line bookkeeping and loop counters.
  always_ff @(posedge clk) begin
    if (close) begin
      line_cnt  <= count_inc;
      last_flag <= in_end;
    end
    case (state)
      ST_LEN: begin
        base <= '0;
        lane <= '0;
        chr  <= '0;
      end
      ST_READ: rd_valid <= in_range;
      ST_LOAD: lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
      ST_CHAR: begin
        if (slot_free) begin
          chr <= chr + 2'd1;
          if (chr == 2'd3) begin
            base <= base + CNT_W'(3);
          end
        end
      end
      default: rd_valid <= rd_valid;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/uu_line_encoder_unit.sv
// Top level of the line encoder: line store, sequencer, group datapath and
// the output register. Depends on uule_pkg, the channel interfaces and uule_ram.
`default_nettype none

// Bytes are taken one per cycle until a line closes, either because
// LINE_BYTES bytes are held or because a byte carries end_of_data. The block
// then stops taking bytes while it sends the line: a length character, four
// characters for every group of three bytes and a newline that carries
// line_done (and stream_done when the line was closed by end_of_data). Each
// group costs three fetches through the single read port of the line store
// and four shifts of the shared group word, and output stalls hold the
// sequence where it is. The line store needs no clearing after reset.
module uu_line_encoder_unit
  import uule_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  uule_byte_if.sink   byte_ch,
  uule_char_if.source char_ch
);

  logic              slot_free;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              emit;
  grp_ctrl_t         ctrl;
  logic [CNT_W-1:0]  line_cnt;
  out_item_t         item;
  out_item_t         out_reg;
  logic              out_valid;

  assign slot_free = !out_valid || char_ch.ready;

  uule_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LINE_BYTES)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (byte_ch.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  uule_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_ch.valid),
    .in_end    (byte_ch.end_of_data),
    .in_ready  (byte_ch.ready),
    .slot_free (slot_free),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .emit      (emit),
    .ctrl      (ctrl),
    .line_cnt  (line_cnt)
  );

  uule_group u_group (
    .clk      (clk),
    .ctrl     (ctrl),
    .rd_data  (rd_data),
    .line_cnt (line_cnt),
    .item     (item)
  );

  // Output register: holds one item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (char_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg <= item;
    end
  end

  assign char_ch.valid       = out_valid;
  assign char_ch.text_char   = out_reg.text_char;
  assign char_ch.line_done   = out_reg.line_done;
  assign char_ch.stream_done = out_reg.stream_done;

`ifndef SYNTH
  // A new item is never loaded over one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("output item overwritten before it was taken");

  // The line store is only read inside the line.
  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ({1'b0, rd_addr} < SUM_W'(LINE_BYTES)) && ({1'b0, rd_addr} < {1'b0, line_cnt}))
    else $error("line store read beyond the held bytes");

  // End of stream is flagged only on the newline that ends a line.
  a_stream_on_newline: assert property (@(posedge clk) disable iff (rst)
    char_ch.valid && char_ch.stream_done |-> char_ch.line_done
      && (char_ch.text_char == NEWLINE))
    else $error("stream end flagged away from a newline");
`endif

endmodule

`default_nettype wire

>>> dv/uu_line_encoder_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of uu_line_encoder_unit: byte streams in, text lines out.
// Depends on uule_pkg, uule_byte_if, uule_char_if and the block itself.

module uu_line_encoder_unit_test;
  import uule_pkg::*;

  // One row of the directed table; typed holds the expected text where it is obvious.
  typedef struct packed {
    logic [BYTE_W-1:0]       data;
    logic                    eod;
    logic [2:0]              ntyped;
    logic [0:5][CHAR_W-1:0]  typed;
  } stim_row_t;

  localparam int N_DIRECTED = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 27;

  logic clk;
  logic rst;

  uule_byte_if byte_ch ();
  uule_char_if char_ch ();

  uu_line_encoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .char_ch (char_ch)
  );

  // Directed rows: extremes, short last groups, zero words and lines of one to five bytes.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 1'b1, 3'd6, '{7'd33, 7'd96, 7'd96, 7'd96, 7'd96, 7'd10}},
    '{8'hFF, 1'b1, 3'd6, '{7'd33, 7'd95, 7'd35, 7'd96, 7'd96, 7'd10}},
    '{8'h40, 1'b1, 3'd6, '{7'd33, 7'd96, 7'd33, 7'd96, 7'd96, 7'd10}},
    '{8'hFF, 1'b0, 3'd0, '0},
    '{8'hFF, 1'b0, 3'd0, '0},
    '{8'hFF, 1'b1, 3'd6, '{7'd35, 7'd95, 7'd95, 7'd95, 7'd95, 7'd10}},
    '{8'h01, 1'b0, 3'd0, '0},
    '{8'h80, 1'b1, 3'd6, '{7'd34, 7'd33, 7'd96, 7'd40, 7'd96, 7'd10}},
    '{8'h55, 1'b0, 3'd0, '0},
    '{8'hAA, 1'b0, 3'd0, '0},
    '{8'h00, 1'b0, 3'd0, '0},
    '{8'h3C, 1'b1, 3'd0, '0},
    '{8'h12, 1'b0, 3'd0, '0},
    '{8'h34, 1'b0, 3'd0, '0},
    '{8'h56, 1'b0, 3'd0, '0},
    '{8'h78, 1'b0, 3'd0, '0},
    '{8'h9A, 1'b1, 3'd0, '0},
    '{8'h00, 1'b0, 3'd0, '0},
    '{8'h00, 1'b0, 3'd0, '0},
    '{8'h00, 1'b1, 3'd6, '{7'd35, 7'd96, 7'd96, 7'd96, 7'd96, 7'd10}}
  };

  // Predictor state: bytes of the line being gathered and how many are held.
  logic [BYTE_W-1:0] line_bytes [LINE_BYTES];
  int unsigned       held;
  out_item_t         line_out [$];
  out_item_t         pending_chars [$];

  int   mismatch_count;
  int   items_sent;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  logic hold_req;

  out_item_t want;
  out_item_t got;

  // Clock, period 20 ns.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // A six-bit value of zero is sent as backquote, any other as value plus 32.
  function automatic logic [CHAR_W-1:0] six_to_char(input logic [5:0] v);
    return (v == 6'd0) ? BACKQUOTE : ({1'b0, v} + CHAR_OFFSET);
  endfunction

  function automatic void add_char(input logic [CHAR_W-1:0] ch, input logic ld,
                                   input logic sd);
    out_item_t c;
    c.text_char   = ch;
    c.line_done   = ld;
    c.stream_done = sd;
    line_out.push_back(c);
  endfunction

  // Takes one byte into the line; when the line closes, line_out gets its text.
  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic eod);
    int unsigned       cnt;
    int unsigned       i;
    logic [WORD_W-1:0] w;
    line_out.delete();
    line_bytes[held] = b;
    held++;
    if (held < LINE_BYTES && !eod) return;
    cnt = held;
    add_char(six_to_char(cnt[5:0]), 1'b0, 1'b0);
    for (i = 0; i < cnt; i += 3) begin
      // Missing bytes of a short last group count as zero.
      w[7:0]   = line_bytes[i];
      w[15:8]  = (i + 1 < cnt) ? line_bytes[i + 1] : 8'h00;
      w[23:16] = (i + 2 < cnt) ? line_bytes[i + 2] : 8'h00;
      add_char(six_to_char(w[5:0]), 1'b0, 1'b0);
      add_char(six_to_char(w[11:6]), 1'b0, 1'b0);
      add_char(six_to_char(w[17:12]), 1'b0, 1'b0);
      add_char(six_to_char(w[23:18]), 1'b0, 1'b0);
    end
    add_char(NEWLINE, 1'b1, eod);
    held = 0;
  endfunction

  task automatic report_char(input string what, input out_item_t exp_c,
                             input out_item_t act_c);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s at %0t: expected char %0d ld %0b sd %0b, got char %0d ld %0b sd %0b",
               what, $realtime, exp_c.text_char, exp_c.line_done, exp_c.stream_done,
               act_c.text_char, act_c.line_done, act_c.stream_done);
    end
  endtask

  // Check every accepted character against the oldest one expected.
  always @(posedge clk) begin
    if (!rst && char_ch.valid && char_ch.ready) begin
      got.text_char   = char_ch.text_char;
      got.line_done   = char_ch.line_done;
      got.stream_done = char_ch.stream_done;
      if (pending_chars.size() == 0) begin
        report_char("unexpected character", '0, got);
      end else begin
        want = pending_chars.pop_front();
        if (got.text_char !== want.text_char || got.line_done !== want.line_done ||
            got.stream_done !== want.stream_done) begin
          report_char("character mismatch", want, got);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      char_ch.ready = 1'b0;
    end else begin
      char_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endfunction

  // Offers one byte until it is taken, then records the text it should cause.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod,
                           input logic [2:0] ntyped, input logic [0:5][CHAR_W-1:0] typed);
    int k;
    out_item_t c;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid = 1'b0;
      @(negedge clk);
    end
    byte_ch.valid       = 1'b1;
    byte_ch.data_byte   = b;
    byte_ch.end_of_data = eod;
    do @(posedge clk); while (!byte_ch.ready);
    encode_byte(b, eod);
    if (ntyped != 0) begin
      for (k = 0; k < ntyped; k++) begin
        c.text_char   = typed[k];
        c.line_done   = (k == ntyped - 1);
        c.stream_done = (k == ntyped - 1) && eod;
        pending_chars.push_back(c);
      end
    end else begin
      for (k = 0; k < line_out.size(); k++) pending_chars.push_back(line_out[k]);
    end
    items_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly short streams, with full lines, lines around the full size and multi-line streams.
  function automatic int pick_length();
    case ($urandom_range(7))
      0, 1:    return $urandom_range(3, 1);
      2, 3:    return $urandom_range(20, 4);
      4:       return LINE_BYTES;
      5:       return $urandom_range(LINE_BYTES + 2, LINE_BYTES - 2);
      6:       return $urandom_range(2 * LINE_BYTES + 5, LINE_BYTES + 1);
      default: return $urandom_range(LINE_BYTES - 1, 21);
    endcase
  endfunction

  task automatic send_stream(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_byte(pick_byte(), k == len - 1, 3'd0, '0);
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    int target;
    int len;
    set_idling(send_pct, recv_pct);
    target = items_sent + ITEMS_PER_PHASE;
    while (items_sent < target) begin
      // The last stream of a phase is cut short so that the phase ends on its target.
      len = pick_length();
      if (len > target - items_sent) len = target - items_sent;
      send_stream(len);
    end
  endtask

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    rst                 = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = '0;
    byte_ch.end_of_data = 1'b0;
    char_ch.ready       = 1'b0;
    hold_req            = 1'b0;
    hold_left           = 0;
    held                = 0;
    mismatch_count      = 0;
    items_sent          = 0;
    set_idling(0, 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].data, directed_rows[r].eod, directed_rows[r].ntyped,
                directed_rows[r].typed);
    end

    // A full line closed by the end flag.
    send_stream(LINE_BYTES);
    random_phase(0, 0);

    // Pause until the output has caught up, then hold the receiver off while
    // bytes keep coming, so that the block fills and stalls its input. The
    // stream spans two lines.
    @(negedge clk);
    byte_ch.valid = 1'b0;
    wait_drained();
    hold_req = 1'b1;
    send_stream(LINE_BYTES + 3);

    random_phase(84, 0);
    random_phase(0, 84);
    random_phase(9, 9);

    @(negedge clk);
    byte_ch.valid = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("uu_line_encoder_unit_test OK");
    end else begin
      $display("uu_line_encoder_unit_test NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("uu_line_encoder_unit_test NOT OK");
    $finish;
  end

endmodule

>>> files.f
sv/uule_pkg.sv
sv/uule_byte_if.sv
sv/uule_char_if.sv
sv/uule_ram.sv
sv/uule_group.sv
sv/uule_seq.sv
sv/uu_line_encoder_unit.sv
dv/uu_line_encoder_unit_test.sv
